### sv/hbtd_pkg.sv
`default_nettype none

package hbtd_pkg;

  // Table geometry and field widths.
  localparam int MAX_NODES  = 512;
  localparam int ADDR_W     = $clog2(MAX_NODES);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int COUNT_BITS = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [IDX_W-1:0]      index_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [SYM_W-1:0]      sym_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam count_t COUNT_MAX = '1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SYMBOL_COUNT = 1'b0;
  localparam cfg_idx_t CFG_TREE_PRESENT = 1'b1;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RIGHT = 2'd1,
    ST_NO_LEFT  = 2'd2,
    ST_NO_TREE  = 2'd3
  } status_e;

  // One node of the code tree, 29 bits.
  typedef struct packed {
    index_t left_index;
    logic   has_left;
    index_t right_index;
    logic   has_right;
    logic   leaf_flag;
    sym_t   leaf_symbol;
  } node_t;

  // Captured input request.
  typedef struct packed {
    logic   kind;
    index_t node_index;
    index_t left_index;
    logic   has_left;
    index_t right_index;
    logic   has_right;
    logic   leaf_flag;
    sym_t   leaf_symbol;
    logic   code_bit;
  } in_item_t;

  // Request in the resolve stage, alongside the node read data.
  typedef struct packed {
    logic    valid;
    logic    kind;
    logic    miss;
    status_e miss_status;
  } stage_t;

  // Resolve stage back to the fetch stage.
  typedef struct packed {
    logic  advance;
    node_t cur;
  } fwd_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    node_t data;
  } wr_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  function automatic logic in_range(input index_t idx);
    return 32'(idx) < 32'(MAX_NODES);
  endfunction

  function automatic addr_t to_addr(input index_t idx);
    return addr_t'(idx);
  endfunction

  // Symbol count saturated to what the done counter can hold.
  function automatic count_t sat_count(input cfg_data_t value);
    logic [63:0] wide;
    wide = 64'(value);
    if (wide > 64'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return count_t'(wide);
  endfunction

endpackage

`default_nettype wire

### sv/hbtd_if.sv
`default_nettype none

// Input request channel.
interface hbtd_in_if import hbtd_pkg::*;;
  logic   valid;
  logic   ready;
  logic   kind;
  index_t node_index;
  index_t left_index;
  logic   has_left;
  index_t right_index;
  logic   has_right;
  logic   leaf_flag;
  sym_t   leaf_symbol;
  logic   code_bit;

  modport source (
    output valid, kind, node_index, left_index, has_left, right_index, has_right,
           leaf_flag, leaf_symbol, code_bit,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, left_index, has_left, right_index, has_right,
           leaf_flag, leaf_symbol, code_bit,
    output ready
  );
endinterface

// Result channel.
interface hbtd_out_if import hbtd_pkg::*;;
  logic       valid;
  logic       ready;
  sym_t       out_symbol;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_symbol, status, last, input ready);
  modport sink (input valid, out_symbol, status, last, output ready);
endinterface

// Configuration write channel.
interface hbtd_cfg_if import hbtd_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/hbtd_node_store.sv
`default_nettype none

module hbtd_node_store import hbtd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire wr_req_t wr_i,
  input  wire rd_req_t rd_i,
  output node_t        rdata_o,
  output node_t        root_o
);

  node_t mem [MAX_NODES];
  node_t rdata_q;
  node_t root_q;

  // Node table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  // Copy of the root node, so the root is always at hand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (wr_i.en && (wr_i.addr == '0)) begin
      root_q <= wr_i.data;
    end
  end

  assign rdata_o = rdata_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

### sv/hbtd_fetch.sv
`default_nettype none

module hbtd_fetch import hbtd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hbtd_in_if.sink   in_i,
  input  wire fwd_t fwd_i,
  output stage_t    stage_o,
  output wr_req_t   wr_o,
  output rd_req_t   rd_o
);

  logic     s1_valid_q;
  in_item_t s1_q;
  stage_t   stage_q;
  stage_t   stage_d;
  logic     s1_go;
  logic     take;
  index_t   child;
  logic     child_has;
  status_e  miss_status;
  logic     miss;

  // Handshake: the input register moves on whenever the resolve stage frees up.
  assign s1_go      = s1_valid_q & fwd_i.advance;
  assign in_i.ready = !s1_valid_q | s1_go;
  assign take       = in_i.valid & in_i.ready;

  // Pick the child that the code bit selects from the current node.
  always_comb begin
    if (s1_q.code_bit) begin
      child       = fwd_i.cur.right_index;
      child_has   = fwd_i.cur.has_right;
      miss_status = ST_NO_RIGHT;
    end else begin
      child       = fwd_i.cur.left_index;
      child_has   = fwd_i.cur.has_left;
      miss_status = ST_NO_LEFT;
    end
    miss = !child_has || !in_range(child);
  end

  // Node load goes straight into the table; a bit request reads the child.
  always_comb begin
    wr_o.en                  = s1_go & (s1_q.kind == KIND_LOAD) & in_range(s1_q.node_index);
    wr_o.addr                = to_addr(s1_q.node_index);
    wr_o.data.left_index     = s1_q.left_index;
    wr_o.data.has_left       = s1_q.has_left;
    wr_o.data.right_index    = s1_q.right_index;
    wr_o.data.has_right      = s1_q.has_right;
    wr_o.data.leaf_flag      = s1_q.leaf_flag;
    wr_o.data.leaf_symbol    = s1_q.leaf_symbol;
    rd_o.en                  = s1_go & (s1_q.kind == KIND_BIT);
    rd_o.addr                = to_addr(child);
    stage_d.valid            = s1_go;
    stage_d.kind             = s1_q.kind;
    stage_d.miss             = miss;
    stage_d.miss_status      = miss_status;
  end

  // Control registers of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      stage_q    <= '0;
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (fwd_i.advance) begin
        stage_q <= stage_d;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q.kind        <= in_i.kind;
      s1_q.node_index  <= in_i.node_index;
      s1_q.left_index  <= in_i.left_index;
      s1_q.has_left    <= in_i.has_left;
      s1_q.right_index <= in_i.right_index;
      s1_q.has_right   <= in_i.has_right;
      s1_q.leaf_flag   <= in_i.leaf_flag;
      s1_q.leaf_symbol <= in_i.leaf_symbol;
      s1_q.code_bit    <= in_i.code_bit;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

### sv/hbtd_resolve.sv
`default_nettype none

module hbtd_resolve import hbtd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbtd_cfg_if.sink   cfg_i,
  hbtd_out_if.source out_o,
  input  wire stage_t stage_i,
  input  wire node_t rdata_i,
  input  wire node_t root_i,
  output fwd_t       fwd_o
);

  typedef enum logic [1:0] {
    WALK_HOLD,
    WALK_ROOT,
    WALK_STEP
  } walk_e;

  cfg_data_t symbol_count_q;
  logic      tree_present_q;
  count_t    done_q;
  logic      at_root_q;
  node_t     cur_q;
  logic      out_valid_q;
  sym_t      out_symbol_q;
  status_e   out_status_q;
  logic      out_last_q;

  count_t    target;
  count_t    done_inc;
  logic      owed;
  walk_e     walk_op;
  logic      has_res;
  logic      emit;
  sym_t      res_symbol;
  status_e   res_status;
  logic      res_last;
  logic      out_free;
  logic      s2_go;
  logic      cfg_take;
  node_t     cur_base;

  assign target   = sat_count(symbol_count_q);
  assign done_inc = done_q + count_t'(1);
  assign owed     = done_q < target;

  // Decide what the request in this stage does to the walk and the output.
  always_comb begin
    walk_op    = WALK_HOLD;
    has_res    = 1'b0;
    emit       = 1'b0;
    res_symbol = '0;
    res_status = ST_OK;
    res_last   = 1'b0;
    if (stage_i.valid) begin
      if (stage_i.kind == KIND_LOAD) begin
        walk_op = WALK_ROOT;
      end else if (owed) begin
        if (!tree_present_q) begin
          walk_op    = WALK_ROOT;
          has_res    = 1'b1;
          res_status = ST_NO_TREE;
        end else if (root_i.leaf_flag) begin
          walk_op    = WALK_ROOT;
          has_res    = 1'b1;
          emit       = 1'b1;
          res_symbol = root_i.leaf_symbol;
          res_last   = (done_inc == target);
        end else if (stage_i.miss) begin
          walk_op    = WALK_ROOT;
          has_res    = 1'b1;
          res_status = stage_i.miss_status;
        end else if (rdata_i.leaf_flag) begin
          walk_op    = WALK_ROOT;
          has_res    = 1'b1;
          emit       = 1'b1;
          res_symbol = rdata_i.leaf_symbol;
          res_last   = (done_inc == target);
        end else begin
          walk_op = WALK_STEP;
        end
      end
    end
  end

  // Only a result blocked by a full output register holds this stage.
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_go    = stage_i.valid && (!has_res || out_free);
  assign cfg_take = cfg_i.valid & cfg_i.ready;

  // Current node as the fetch stage must see it, after this stage completes.
  assign cur_base = at_root_q ? root_i : cur_q;
  always_comb begin
    fwd_o.advance = !stage_i.valid || s2_go;
    fwd_o.cur     = cur_base;
    if (stage_i.valid) begin
      case (walk_op)
        WALK_ROOT: fwd_o.cur = root_i;
        WALK_STEP: fwd_o.cur = rdata_i;
        WALK_HOLD: fwd_o.cur = cur_base;
        default:   fwd_o.cur = cur_base;
      endcase
    end
  end

  // Configuration registers, walk position and symbol counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= '0;
      tree_present_q <= 1'b0;
      done_q         <= '0;
      at_root_q      <= 1'b1;
    end else if (cfg_take) begin
      case (cfg_i.index)
        CFG_SYMBOL_COUNT: begin
          symbol_count_q <= cfg_i.data;
          done_q         <= '0;
          at_root_q      <= 1'b1;
        end
        CFG_TREE_PRESENT: begin
          tree_present_q <= cfg_i.data[0];
        end
        default: begin
          tree_present_q <= tree_present_q;
        end
      endcase
    end else if (s2_go) begin
      if (walk_op == WALK_ROOT) begin
        at_root_q <= 1'b1;
      end else if (walk_op == WALK_STEP) begin
        at_root_q <= 1'b0;
      end
      if (emit) begin
        done_q <= done_inc;
      end
    end
  end

  // Contents of the current inner node.
  always_ff @(posedge clk_i) begin
    if (s2_go && (walk_op == WALK_STEP)) begin
      cur_q <= rdata_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && has_res) begin
      out_symbol_q <= res_symbol;
      out_status_q <= res_status;
      out_last_q   <= res_last;
    end
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.out_symbol = out_symbol_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

### sv/huffman_bit_tree_decoder_unit.sv
// Channel   Role    Contents                                   Accepted when
// -------   -----   ----------------------------------------   -------------------
// in_i      sink    kind, node fields, code_bit                in_i.valid & ready
// out_o     source  out_symbol, status, last                   out_o.valid & ready
// cfg_i     sink    index, data (symbol_count, tree_present)   cfg_i.valid & ready
//
// One request per cycle, node loads and code bits alike, unless a result stalls at the
// output; a result passes the input and stage registers into the output register.
// The next node read address is taken from the registered read data of the bit
// before, so the walk never waits on the table.
// Reset is asynchronous and clears the walk, counter and registers, not the table.
// A result the sink does not take stalls the next result; input stalls once the input
// register is full behind it.
`default_nettype none

module huffman_bit_tree_decoder_unit import hbtd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbtd_in_if.sink    in_i,
  hbtd_out_if.source out_o,
  hbtd_cfg_if.sink   cfg_i
);

  fwd_t    fwd;
  stage_t  stage;
  wr_req_t wr_req;
  rd_req_t rd_req;
  node_t   rdata;
  node_t   root;

  // Input register, child selection and table access.
  hbtd_fetch u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .fwd_i   (fwd),
    .stage_o (stage),
    .wr_o    (wr_req),
    .rd_o    (rd_req)
  );

  // Node table and root copy.
  hbtd_node_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata),
    .root_o  (root)
  );

  // Walk state, counting and output register.
  hbtd_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .out_o   (out_o),
    .stage_i (stage),
    .rdata_i (rdata),
    .root_i  (root),
    .fwd_o   (fwd)
  );

endmodule

`default_nettype wire

### sv/hbtd_checker.sv
`default_nettype none

module hbtd_checker import hbtd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire sym_t       out_symbol_i,
  input wire logic [1:0] out_status_i,
  input wire logic       out_last_i
);

  // Reset empties the output register.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_symbol_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Input is refused only when a result is blocked at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output back-pressure");

  // Error results carry symbol zero and never end the message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> (out_symbol_i == '0) && !out_last_i)
    else $error("error result with symbol or last set");

  // Input ready is never unknown while a handshake takes place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !$isunknown(in_ready_i))
    else $error("input ready unknown");

endmodule

bind huffman_bit_tree_decoder_unit hbtd_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.out_symbol),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

`default_nettype wire
